// ----- hw/rtl/ftpclt_pkg.sv -----
// ftpclt_pkg: shared types, codes and helpers for the FTP control line tracker.
// No dependencies; used by every module under hw/rtl.
package ftpclt_pkg;

    localparam int unsigned LINE_MAX   = 4096;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned HEAD_N     = 5;
    localparam int unsigned QUEUE_N    = 4;
    localparam int unsigned QPTR_W     = 2;
    localparam int unsigned QCNT_W     = 3;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [CNT_W-1:0] LINE_MAX_C = CNT_W'(LINE_MAX);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [31:0] CMD_CWD  = 32'h43574420;
    localparam logic [31:0] CMD_XCWD = 32'h58435744;
    localparam logic [31:0] CMD_CDUP = 32'h43445550;
    localparam logic [31:0] CMD_XCUP = 32'h58435550;
    localparam logic [31:0] CMD_PWD  = 32'h50574420;
    localparam logic [31:0] CMD_XPWD = 32'h58505744;
    localparam logic [31:0] CMD_REIN = 32'h5245494E;
    localparam logic [31:0] CMD_RETR = 32'h52455452;

    localparam logic [9:0] CODE_DIR_MADE = 10'd257;

    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_CWD  = 3'd1,
        PEND_CDUP = 3'd2,
        PEND_PWD  = 3'd3,
        PEND_REIN = 3'd4
    } pend_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_FETCH_FILE = 3'd1,
        ACT_ENTER_DIR  = 3'd2,
        ACT_PARENT_DIR = 3'd3,
        ACT_DIR_REPORT = 3'd4,
        ACT_RESET_ROOT = 3'd5
    } action_t;

    // summary of one finished line, handed from front to back
    typedef struct packed {
        logic                  from_client;
        logic [CNT_W-1:0]      byte_count;
        logic [HEAD_N*8-1:0]   head;        // byte 0 in the lowest bits
        logic [2:0]            break_run;
        logic                  seen_text;
        logic                  seen_nul;
        logic                  too_long;
    } line_sum_t;

    typedef struct packed {
        logic                  awaiting_reply;
        action_t               action;
        logic [CNT_W-1:0]      args_length;
        logic [2:0]            args_start;
        logic [9:0]            reply_code;
        logic [2:0]            command_length;
        logic [31:0]           command_word;
        logic                  parsed_ok;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ----- hw/rtl/ftp_control_line_tracker_core.sv -----
// ftp_control_line_tracker_core: top level of the FTP control line tracker.
// Depends on ftpclt_pkg, ftpclt_front, ftpclt_queue and ftpclt_back.
//
// Usage:
//   Slave channel: one control-line byte per beat. s_axis_tdata is the byte,
//   s_axis_tuser is 1 for a client command line and 0 for a server reply,
//   s_axis_tlast marks the last byte of the line (tuser is taken on that beat).
//   Master channel: one result beat per line, no beats for other bytes.
//   Throughput: one byte per cycle, sustained, with the master side ready.
//   After the tlast beat the line summary passes through the summary queue into
//   the output register, and m_axis_tvalid rises once it is in that register.
//   With the master side ready the input never stalls, whatever the line
//   length; a stalled master holds one result in the output register and
//   fills the four-entry summary queue, and only then is s_axis_tready dropped.
//   Reset (aresetn low, synchronous) clears the partial line, the queue, the
//   output register and the awaited directory command.
//   Bytes past 4096 in one line are counted as over-long and the line fails.
module ftp_control_line_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  logic        s_axis_tuser,   // [0] from_client
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] parsed_ok, [32:1] command_word, [35:33] command_length,
    // [45:36] reply_code, [48:46] args_start, [61:49] args_length,
    // [64:62] action, [65] awaiting_reply, [71:66] zero
    output logic [ftpclt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  q_full;
    logic                  beat_en;
    logic                  push;
    ftpclt_pkg::line_sum_t push_data;
    logic                  pop;
    logic                  head_valid;
    ftpclt_pkg::line_sum_t head_data;
    ftpclt_pkg::result_t   res;

    assign s_axis_tready = !q_full;
    assign beat_en       = s_axis_tvalid && !q_full;

    ftpclt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_en     (beat_en),
        .line_byte   (s_axis_tdata),
        .from_client (s_axis_tuser),
        .end_of_line (s_axis_tlast),
        .push        (push),
        .push_data   (push_data)
    );

    ftpclt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ftpclt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_valid (head_valid),
        .line       (head_data),
        .pop        (pop),
        .res_valid  (m_axis_tvalid),
        .res        (res),
        .res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {
        (ftpclt_pkg::OUT_DATA_W - $bits(ftpclt_pkg::result_t))'(0), res
    };

endmodule

// ----- hw/rtl/ftpclt_front.sv -----
// ftpclt_front: per-beat line statistics (length, head bytes, CR/LF run, NUL).
// Pushes one line_sum_t per end-of-line beat. Depends on ftpclt_pkg.
module ftpclt_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    beat_en,
    input  logic [7:0]              line_byte,
    input  logic                    from_client,
    input  logic                    end_of_line,
    output logic                    push,
    output ftpclt_pkg::line_sum_t   push_data
);

    logic [ftpclt_pkg::CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [7:0]                    head_reg [ftpclt_pkg::HEAD_N];
    logic [7:0]                    head_next [ftpclt_pkg::HEAD_N];
    logic [2:0]                    run_reg, run_next;
    logic                          text_reg, text_next;
    logic                          nul_reg, nul_next;
    logic                          long_reg, long_next;
    logic                          is_break;

    always_comb begin
        byte_count_next = byte_count_reg;
        long_next       = long_reg;
        for (int i = 0; i < ftpclt_pkg::HEAD_N; i++) begin
            head_next[i] = head_reg[i];
        end
        if (byte_count_reg != ftpclt_pkg::LINE_MAX_C) begin
            for (int i = 0; i < ftpclt_pkg::HEAD_N; i++) begin
                if (byte_count_reg == ftpclt_pkg::CNT_W'(i)) begin
                    head_next[i] = line_byte;
                end
            end
            byte_count_next = byte_count_reg + 1'b1;
        end else begin
            long_next = 1'b1;
        end
        is_break  = (line_byte == ftpclt_pkg::CH_CR) || (line_byte == ftpclt_pkg::CH_LF);
        run_next  = is_break ? ((run_reg == 3'd7) ? run_reg : run_reg + 3'd1) : 3'd0;
        text_next = text_reg | ~is_break;
        nul_next  = nul_reg | (line_byte == ftpclt_pkg::CH_NUL);
    end

    always_comb begin
        push                  = beat_en & end_of_line;
        push_data.from_client = from_client;
        push_data.byte_count  = byte_count_next;
        for (int i = 0; i < ftpclt_pkg::HEAD_N; i++) begin
            push_data.head[i*8 +: 8] = head_next[i];
        end
        push_data.break_run   = run_next;
        push_data.seen_text   = text_next;
        push_data.seen_nul    = nul_next;
        push_data.too_long    = long_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            run_reg        <= '0;
            text_reg       <= 1'b0;
            nul_reg        <= 1'b0;
            long_reg       <= 1'b0;
        end else if (beat_en) begin
            if (end_of_line) begin
                byte_count_reg <= '0;
                run_reg        <= '0;
                text_reg       <= 1'b0;
                nul_reg        <= 1'b0;
                long_reg       <= 1'b0;
            end else begin
                byte_count_reg <= byte_count_next;
                run_reg        <= run_next;
                text_reg       <= text_next;
                nul_reg        <= nul_next;
                long_reg       <= long_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_en) begin
            for (int i = 0; i < ftpclt_pkg::HEAD_N; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

endmodule

// ----- hw/rtl/ftpclt_queue.sv -----
// ftpclt_queue: small FIFO of line summaries between front and back.
// Depends on ftpclt_pkg.
module ftpclt_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ftpclt_pkg::line_sum_t   push_data,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output ftpclt_pkg::line_sum_t   head_data
);

    ftpclt_pkg::line_sum_t                 store_reg [ftpclt_pkg::QUEUE_N];
    logic [ftpclt_pkg::QPTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [ftpclt_pkg::QCNT_W-1:0]         count_reg;

    assign full       = (count_reg == ftpclt_pkg::QCNT_W'(ftpclt_pkg::QUEUE_N));
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/ftpclt_back.sv -----
// ftpclt_back: parses one line summary per cycle unless an untaken result stalls it,
// tracks the awaited directory command and holds the result register. Depends on ftpclt_pkg.
module ftpclt_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    line_valid,
    input  ftpclt_pkg::line_sum_t   line,
    output logic                    pop,
    output logic                    res_valid,
    output ftpclt_pkg::result_t     res,
    input  logic                    res_ready
);

    ftpclt_pkg::pend_t             pend_reg, pend_next;
    ftpclt_pkg::result_t           res_reg, res_next;
    logic                          res_valid_reg;

    logic [7:0]                    h [ftpclt_pkg::HEAD_N];
    logic [ftpclt_pkg::CNT_W-1:0]  len;
    logic [2:0]                    strip;
    logic                          line_ok;
    logic [2:0]                    cl;
    logic                          cl_ok;
    logic                          letters_ok;
    logic [31:0]                   word;
    logic [ftpclt_pkg::CNT_W-1:0]  cl_plus1;
    logic [3:0]                    d0, d1, d2;
    logic [9:0]                    code;
    logic [ftpclt_pkg::CNT_W-1:0]  alen;

    always_comb begin
        for (int i = 0; i < ftpclt_pkg::HEAD_N; i++) begin
            h[i] = line.head[i*8 +: 8];
        end
        if (line.from_client) begin
            strip = (line.break_run > 3'd4) ? 3'd4 : line.break_run;
        end else begin
            strip = (line.break_run > 3'd2) ? 3'd2 : line.break_run;
        end
        len     = line.byte_count - ftpclt_pkg::CNT_W'(strip);
        line_ok = !line.seen_nul && !line.too_long && line.seen_text
                  && (len >= ftpclt_pkg::CNT_W'(3));

        cl_ok = 1'b1;
        if ((len == ftpclt_pkg::CNT_W'(3)) || (h[3] == ftpclt_pkg::CH_SPACE)) begin
            cl = 3'd3;
        end else if ((len == ftpclt_pkg::CNT_W'(4)) || (h[4] == ftpclt_pkg::CH_SPACE)) begin
            cl = 3'd4;
        end else begin
            cl    = 3'd0;
            cl_ok = 1'b0;
        end
        letters_ok = ftpclt_pkg::is_letter(h[0]) && ftpclt_pkg::is_letter(h[1])
                     && ftpclt_pkg::is_letter(h[2])
                     && ((cl != 3'd4) || ftpclt_pkg::is_letter(h[3]));
        word = {ftpclt_pkg::to_upper(h[0]), ftpclt_pkg::to_upper(h[1]),
                ftpclt_pkg::to_upper(h[2]),
                (cl == 3'd4) ? ftpclt_pkg::to_upper(h[3]) : ftpclt_pkg::CH_SPACE};
        cl_plus1 = ftpclt_pkg::CNT_W'(cl) + 1'b1;

        d0   = h[0][3:0];
        d1   = h[1][3:0];
        d2   = h[2][3:0];
        code = 10'({6'd0, d0} * 10'd100) + 10'({6'd0, d1} * 10'd10) + {6'd0, d2};
        alen = (len > ftpclt_pkg::CNT_W'(4)) ? (len - ftpclt_pkg::CNT_W'(4)) : '0;
    end

    always_comb begin
        res_next  = '0;
        pend_next = pend_reg;
        if (line.from_client) begin
            pend_next = ftpclt_pkg::PEND_NONE;
            if (line_ok && cl_ok && letters_ok) begin
                res_next.parsed_ok      = 1'b1;
                res_next.command_word   = word;
                res_next.command_length = cl;
                if (len > cl_plus1) begin
                    res_next.args_start  = cl + 3'd1;
                    res_next.args_length = len - cl_plus1;
                end
                priority if ((word == ftpclt_pkg::CMD_CWD) || (word == ftpclt_pkg::CMD_XCWD)) begin
                    pend_next = ftpclt_pkg::PEND_CWD;
                end else if ((word == ftpclt_pkg::CMD_CDUP)
                             || (word == ftpclt_pkg::CMD_XCUP)) begin
                    pend_next = ftpclt_pkg::PEND_CDUP;
                end else if ((word == ftpclt_pkg::CMD_PWD)
                             || (word == ftpclt_pkg::CMD_XPWD)) begin
                    pend_next = ftpclt_pkg::PEND_PWD;
                end else if (word == ftpclt_pkg::CMD_REIN) begin
                    pend_next = ftpclt_pkg::PEND_REIN;
                end else if (word == ftpclt_pkg::CMD_RETR) begin
                    res_next.action = ftpclt_pkg::ACT_FETCH_FILE;
                end else begin
                    pend_next = ftpclt_pkg::PEND_NONE;
                end
            end
        end else if (line_ok && ftpclt_pkg::is_digit(h[0]) && ftpclt_pkg::is_digit(h[1])
                     && ftpclt_pkg::is_digit(h[2])) begin
            res_next.parsed_ok  = 1'b1;
            res_next.reply_code = code;
            if (len > ftpclt_pkg::CNT_W'(4)) begin
                res_next.args_start  = 3'd4;
                res_next.args_length = alen;
            end
            if (pend_reg != ftpclt_pkg::PEND_NONE) begin
                priority if ((code >= 10'd400) || (code < 10'd100)) begin
                    pend_next = ftpclt_pkg::PEND_NONE;
                end else if ((code >= 10'd200) && (code < 10'd300)) begin
                    pend_next = ftpclt_pkg::PEND_NONE;
                    unique case (pend_reg)
                        ftpclt_pkg::PEND_CWD:  res_next.action = ftpclt_pkg::ACT_ENTER_DIR;
                        ftpclt_pkg::PEND_CDUP: res_next.action = ftpclt_pkg::ACT_PARENT_DIR;
                        ftpclt_pkg::PEND_PWD: begin
                            if ((code == ftpclt_pkg::CODE_DIR_MADE)
                                && (alen >= ftpclt_pkg::CNT_W'(2))
                                && (h[4] == ftpclt_pkg::CH_QUOTE)) begin
                                res_next.action = ftpclt_pkg::ACT_DIR_REPORT;
                            end
                        end
                        ftpclt_pkg::PEND_REIN: res_next.action = ftpclt_pkg::ACT_RESET_ROOT;
                        default:               res_next.action = ftpclt_pkg::ACT_NONE;
                    endcase
                end else begin
                    pend_next = pend_reg;
                end
            end
        end
        res_next.awaiting_reply = (pend_next != ftpclt_pkg::PEND_NONE);
    end

    assign pop       = line_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= ftpclt_pkg::PEND_NONE;
            res_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                pend_reg      <= pend_next;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- tb/ftp_control_line_tracker_core_tb.sv -----
// Self-checking testbench for ftp_control_line_tracker_core: directed lines, then random lines,
// with stream idling on both sides and results checked against a local line predictor.
// Depends on ftpclt_pkg and the ftp_control_line_tracker_core RTL.
`timescale 1ns / 1ps

module ftp_control_line_tracker_core_tb;
    import ftpclt_pkg::*;

    localparam bit FROM_CLIENT = 1'b1;
    localparam bit FROM_SERVER = 1'b0;
    localparam int RAND_BYTES  = 1200;
    localparam int HOLD_CYCLES = 80;
    localparam int CODE_PRELIM = 100;
    localparam int CODE_OK     = 200;
    localparam int CODE_MORE   = 300;
    localparam int CODE_FAIL   = 400;
    localparam int NVERBS      = 14;

    typedef struct {
        bit         client;
        string      head;
        logic [7:0] fill_b;
        int         fill_n;
        string      tail;
        bit         typed;
        result_t    want;
    } line_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // line predictor state
    logic [CNT_W-1:0] ln_count  = '0;
    logic [7:0]       ln_head [HEAD_N] = '{default: 8'h00};
    logic [2:0]       ln_breaks = '0;
    bit               ln_text   = 1'b0;
    bit               ln_nul    = 1'b0;
    bit               ln_long   = 1'b0;
    pend_t            dir_wait  = PEND_NONE;

    result_t    result_q [$];
    line_row_t  dir_rows [$];
    logic [7:0] line_buf [$];
    bit         line_client;
    int         mismatches = 0;
    int         burst_left = 0;
    bit         eager      = 1'b0;
    bit         hold_go    = 1'b0;
    int         rand_bytes = 0;

    string verbs [NVERBS] = '{"CWD", "XCWD", "CDUP", "XCUP", "PWD", "XPWD", "REIN",
                              "RETR", "NOOP", "USER", "LIST", "TYPE", "QUIT", "RETR"};
    string lead_digits = "012223459";

    ftp_control_line_tracker_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("ftp_control_line_tracker_core_tb failed");
        $finish;
    end

    function automatic result_t mk_res(input bit ok, input logic [31:0] word,
                                       input int clen, input int code, input int astart,
                                       input int alen, input action_t act, input bit waiting);
        result_t r;
        r = '0;
        r.parsed_ok      = ok;
        r.command_word   = word;
        r.command_length = 3'(clen);
        r.reply_code     = 10'(code);
        r.args_start     = 3'(astart);
        r.args_length    = CNT_W'(alen);
        r.action         = act;
        r.awaiting_reply = waiting;
        return r;
    endfunction

    function automatic string res_str(input result_t r);
        return $sformatf("ok=%0d word=%h clen=%0d code=%0d astart=%0d alen=%0d act=%0d wait=%0d",
                         r.parsed_ok, r.command_word, r.command_length, r.reply_code,
                         r.args_start, r.args_length, r.action, r.awaiting_reply);
    endfunction

    // advances the line state by one byte; returns 1 with the line's result on its last byte
    function automatic bit track_byte(input logic [7:0] b, input bit client, input bit last,
                                      output result_t r);
        int         len;
        int         cl;
        int         code;
        int         alen;
        logic [7:0] c;
        logic [31:0] word;
        bit         ok;
        r = '0;
        if (ln_count < LINE_MAX_C) begin
            if (ln_count < HEAD_N) ln_head[ln_count] = b;
            ln_count = ln_count + 1'b1;
        end else begin
            ln_long = 1'b1;
        end
        if (b == CH_CR || b == CH_LF) begin
            if (ln_breaks != 3'd7) ln_breaks = ln_breaks + 1'b1;
        end else begin
            ln_breaks = '0;
            ln_text   = 1'b1;
        end
        if (b == CH_NUL) ln_nul = 1'b1;
        if (!last) return 1'b0;

        ok = !(ln_nul || ln_long || !ln_text);
        if (client) begin
            dir_wait = PEND_NONE;
            len = int'(ln_count) - ((ln_breaks > 3'd4) ? 4 : int'(ln_breaks));
            cl  = 0;
            if (ok && len >= 3) begin
                if (len == 3 || ln_head[3] == CH_SPACE) cl = 3;
                else if (len == 4 || ln_head[4] == CH_SPACE) cl = 4;
            end
            ok   = ok && cl != 0;
            word = '0;
            for (int i = 0; i < 4; i++) begin
                c = CH_SPACE;
                if (i < cl) begin
                    c = ln_head[i];
                    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
                    else if (!(c >= 8'h41 && c <= 8'h5A)) ok = 1'b0;
                end
                word = {word[23:0], c};
            end
            if (ok) begin
                r.parsed_ok      = 1'b1;
                r.command_word   = word;
                r.command_length = 3'(cl);
                if (len > cl + 1) begin
                    r.args_start  = 3'(cl + 1);
                    r.args_length = CNT_W'(len - cl - 1);
                end
                if (word == CMD_CWD || word == CMD_XCWD) dir_wait = PEND_CWD;
                else if (word == CMD_CDUP || word == CMD_XCUP) dir_wait = PEND_CDUP;
                else if (word == CMD_PWD || word == CMD_XPWD) dir_wait = PEND_PWD;
                else if (word == CMD_REIN) dir_wait = PEND_REIN;
                else if (word == CMD_RETR) r.action = ACT_FETCH_FILE;
            end
        end else begin
            len  = int'(ln_count) - ((ln_breaks > 3'd2) ? 2 : int'(ln_breaks));
            code = 0;
            alen = 0;
            ok   = ok && len >= 3;
            for (int i = 0; i < 3; i++) begin
                if (ok) begin
                    c = ln_head[i];
                    if (c < 8'h30 || c > 8'h39) ok = 1'b0;
                    else code = code * 10 + int'(c - 8'h30);
                end
            end
            if (ok) begin
                r.parsed_ok  = 1'b1;
                r.reply_code = 10'(code);
                if (len > 4) begin
                    alen          = len - 4;
                    r.args_start  = 3'd4;
                    r.args_length = CNT_W'(alen);
                end
                if (dir_wait != PEND_NONE) begin
                    if (code >= CODE_FAIL || code < CODE_PRELIM) begin
                        dir_wait = PEND_NONE;
                    end else if (code >= CODE_OK && code < CODE_MORE) begin
                        case (dir_wait)
                            PEND_CWD:  r.action = ACT_ENTER_DIR;
                            PEND_CDUP: r.action = ACT_PARENT_DIR;
                            PEND_PWD: begin
                                if (code == int'(CODE_DIR_MADE) && alen >= 2
                                    && ln_head[4] == CH_QUOTE)
                                    r.action = ACT_DIR_REPORT;
                            end
                            PEND_REIN: r.action = ACT_RESET_ROOT;
                            default:   r.action = ACT_NONE;
                        endcase
                        dir_wait = PEND_NONE;
                    end
                end
            end
        end
        r.awaiting_reply = (dir_wait != PEND_NONE);
        ln_count  = '0;
        ln_breaks = '0;
        ln_text   = 1'b0;
        ln_nul    = 1'b0;
        ln_long   = 1'b0;
        return 1'b1;
    endfunction

    task automatic add_row(input bit client, input string head, input logic [7:0] fill_b,
                           input int fill_n, input string tail, input bit typed,
                           input result_t want);
        line_row_t row;
        row.client = client;
        row.head   = head;
        row.fill_b = fill_b;
        row.fill_n = fill_n;
        row.tail   = tail;
        row.typed  = typed;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic push_args();
        int n;
        line_buf.push_back(($urandom_range(0, 7) == 0) ? 8'h2D : CH_SPACE);
        if ($urandom_range(0, 1) != 0) line_buf.push_back(CH_QUOTE);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        repeat (n)
            line_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(32, 126)));
    endtask

    task automatic random_line();
        int kind;
        int n;
        line_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            line_client = 1'($urandom);
            n = $urandom_range(1, 10);
            repeat (n) line_buf.push_back(8'($urandom));
        end else if (kind == 9) begin
            // cut-short line
            line_client = 1'($urandom);
            n = $urandom_range(1, 3);
            repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
        end else if (kind <= 4) begin
            line_client = FROM_CLIENT;
            if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(2, 5);
                repeat (n)
                    line_buf.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(65, 90)));
            end else begin
                push_str(verbs[$urandom_range(0, NVERBS - 1)]);
            end
            foreach (line_buf[i])
                if (line_buf[i] >= 8'h41 && line_buf[i] <= 8'h5A && $urandom_range(0, 1) != 0)
                    line_buf[i] = line_buf[i] | 8'h20;
            if ($urandom_range(0, 1) != 0) push_args();
        end else begin
            line_client = FROM_SERVER;
            if ($urandom_range(0, 3) == 0) begin
                push_str("257");
            end else begin
                line_buf.push_back(lead_digits[$urandom_range(0, 8)]);
                repeat (2) line_buf.push_back(8'($urandom_range(48, 57)));
            end
            if ($urandom_range(0, 9) == 0) line_buf[$urandom_range(0, 2)] = 8'($urandom);
            if ($urandom_range(0, 4) != 0) push_args();
        end
        n = $urandom_range(0, 5);
        repeat (n) line_buf.push_back(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
    endtask

    // offers line_buf beat by beat; the last beat carries the direction and tlast
    task automatic send_line(input bit client, input bit typed, input result_t want);
        result_t r;
        bit      taken;
        bit      last;
        int      gap;
        for (int i = 0; i < line_buf.size(); i++) begin
            if (burst_left == 0) begin
                gap = eager ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                               : $urandom_range(0, 2));
                repeat (gap) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            last = (i == line_buf.size() - 1);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= line_buf[i];
            s_axis_tuser  <= last ? client : 1'($urandom);
            s_axis_tlast  <= last;
            do begin
                @(negedge aclk);
                taken = s_axis_tready;
                @(posedge aclk);
            end while (!taken);
            burst_left--;
            if (track_byte(line_buf[i], client, last, r))
                result_q.push_back(typed ? want : r);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: ready runs and stalls of random length, one long hold on request
    initial begin
        bit rdy_phase;
        int run_left;
        int hold_left;
        bit hold_done;
        rdy_phase = 1'b0;
        run_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    rdy_phase = !rdy_phase;
                    if (rdy_phase)
                        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                               : $urandom_range(1, 16);
                    else
                        run_left = $urandom_range(1, 6);
                end
                run_left--;
                m_axis_tready <= rdy_phase;
            end
        end
    end

    task automatic check_beat(input logic [OUT_DATA_W-1:0] beat);
        result_t got;
        result_t want;
        got = result_t'(beat[$bits(result_t)-1:0]);
        if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %s", res_str(got));
        end else begin
            want = result_q.pop_front();
            if (got.parsed_ok !== want.parsed_ok || got.command_word !== want.command_word
                || got.command_length !== want.command_length
                || got.reply_code !== want.reply_code || got.args_start !== want.args_start
                || got.args_length !== want.args_length || got.action !== want.action
                || got.awaiting_reply !== want.awaiting_reply
                || beat[OUT_DATA_W-1:$bits(result_t)] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch\n  exp %s\n  got %s pad=%h", res_str(want),
                             res_str(got), beat[OUT_DATA_W-1:$bits(result_t)]);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata);
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        aresetn       <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(FROM_SERVER, "220 ready\015\012", 8'h00, 0, "", 1'b1,
                mk_res(1, 0, 0, 220, 4, 5, ACT_NONE, 0));
        add_row(FROM_CLIENT, "retr f.txt\015\012", 8'h00, 0, "", 1'b1,
                mk_res(1, CMD_RETR, 4, 0, 5, 5, ACT_FETCH_FILE, 0));
        add_row(FROM_SERVER, "999", 8'hFF, 1, "", 1'b1,
                mk_res(1, 0, 0, 999, 0, 0, ACT_NONE, 0));
        add_row(FROM_CLIENT, "CWD dir\015\012", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "150 x", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "250 ok\015\012", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "XCUP", 8'h00, 0, "", 1'b0, '0);
        // bad reply keeps the awaited command
        add_row(FROM_SERVER, "ab", 8'h00, 0, "", 1'b1, mk_res(0, 0, 0, 0, 0, 0, ACT_NONE, 1));
        add_row(FROM_SERVER, "350 wait", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "200 ok", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "pwd\015\012\015\012", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "257 \"/\"", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "XPWD", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "257 x", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "REIN\015\012", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "220 hi", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "CDUP", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "099 no", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "CWD a", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "550 no\015\012", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "CWD a", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "NOOP", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "CWD a", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_CLIENT, "AB1 x", 8'h00, 0, "", 1'b1, '0);
        add_row(FROM_CLIENT, "STORE x", 8'h00, 0, "", 1'b1, '0);
        add_row(FROM_CLIENT, "\015\012", 8'h00, 0, "", 1'b1, '0);
        add_row(FROM_CLIENT, "CWD ", CH_NUL, 1, "x", 1'b1, '0);
        add_row(FROM_CLIENT, "cwd\015\012\015\012\015\012", 8'h00, 0, "", 1'b0, '0);
        add_row(FROM_SERVER, "200\015\012\015\012", 8'h00, 0, "", 1'b0, '0);
        // longest line that still parses, then one byte too many
        add_row(FROM_CLIENT, "RETR ", 8'h78, 4091, "", 1'b1,
                mk_res(1, CMD_RETR, 4, 0, 5, 4091, ACT_FETCH_FILE, 0));
        add_row(FROM_CLIENT, "RETR ", 8'h78, 4092, "", 1'b1, '0);

        foreach (dir_rows[k]) begin
            line_buf.delete();
            push_str(dir_rows[k].head);
            repeat (dir_rows[k].fill_n) line_buf.push_back(dir_rows[k].fill_b);
            push_str(dir_rows[k].tail);
            send_line(dir_rows[k].client, dir_rows[k].typed, dir_rows[k].want);
        end
        drain();

        while (rand_bytes < RAND_BYTES) begin
            if (!hold_go && rand_bytes >= RAND_BYTES / 2) begin
                // receiver holds off while lines keep coming, so the queue backs up
                eager   = 1'b1;
                hold_go = 1'b1;
                repeat (16) begin
                    random_line();
                    send_line(line_client, 1'b0, '0);
                end
                eager = 1'b0;
                drain();
            end
            if ($urandom_range(0, 15) == 0) eager = !eager;
            random_line();
            rand_bytes += line_buf.size();
            send_line(line_client, 1'b0, '0);
        end

        drain();
        repeat (8) @(posedge aclk);
        mismatches += result_q.size();
        if (mismatches == 0) begin
            $display("ftp_control_line_tracker_core_tb passed");
        end else begin
            $display("ftp_control_line_tracker_core_tb failed");
        end
        $finish;
    end

endmodule

// ----- ftp_control_line_tracker_core.f -----
hw/rtl/ftpclt_pkg.sv
hw/rtl/ftpclt_front.sv
hw/rtl/ftpclt_queue.sv
hw/rtl/ftpclt_back.sv
hw/rtl/ftp_control_line_tracker_core.sv
tb/ftp_control_line_tracker_core_tb.sv
